// ----- src/mcmb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mcmb_pkg;

  // Field widths
  localparam int ID_W      = 3;
  localparam int OP_W      = 2;
  localparam int LEN_W     = 4;
  localparam int DATA_W    = 64;
  localparam int CNT_W     = 32;
  localparam int STAT_W    = 2;
  localparam int DLOG_W    = 3;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  // Channel matrix: one ring per (destination, source) pair
  localparam int NUM_IDS   = 1 << ID_W;
  localparam int CH_W      = 2 * ID_W;
  localparam int NUM_CH    = 1 << CH_W;

  localparam int MSG_BYTES      = 8;
  localparam int RING_SLOTS_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [DLOG_W-1:0] DLOG_RESET = DLOG_W'(4);
  localparam logic [CFG_W-1:0]  MASK_RESET = '0;

  typedef enum logic [OP_W-1:0] {
    OP_SEND = 2'd0,
    OP_RECV = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_NOCH  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASK  = 1'b0,
    CFG_DEPTH = 1'b1
  } cfg_idx_e;

  // Classified command handed from front to back
  typedef struct packed {
    logic              exists;
    op_e               op;
    logic [CH_W-1:0]   ch;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    logic [DLOG_W-1:0] dlog;
  } cmd_t;

  // Result beat
  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic [CNT_W-1:0]  enq;
    logic [CNT_W-1:0]  deq;
  } res_t;

  // Keep the low len bytes
  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < DATA_W / 8; i++) begin
      m[8*i +: 8] = (LEN_W'(i) < len) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- src/mcmb_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mcmb_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Store incoming beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not grow on push");
  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop && !do_push |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("queue count did not shrink on pop");
`endif

endmodule

`default_nettype wire

// ----- src/mcmb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mcmb_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mcmb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mcmb_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                           push_i,
  output logic                                full_o,
  input  wire logic [mcmb_pkg::OP_W-1:0]      op_i,
  input  wire logic [mcmb_pkg::ID_W-1:0]      src_id_i,
  input  wire logic [mcmb_pkg::ID_W-1:0]      dst_id_i,
  input  wire logic [mcmb_pkg::LEN_W-1:0]     length_in_i,
  input  wire logic [mcmb_pkg::DATA_W-1:0]    data_in_i,
  output mcmb_pkg::cmd_t                      cmd_o,
  output logic                                cmd_push_o,
  input  wire logic                           cmd_full_i
);

  import mcmb_pkg::*;

  logic [CFG_W-1:0]  reg_mask_q;
  logic [DLOG_W-1:0] dlog_q;
  logic              dst_ok, src_ok;
  logic [LEN_W-1:0]  len_sat;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_mask_q <= MASK_RESET;
      dlog_q     <= DLOG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MASK:  reg_mask_q <= cfg_wdata_i;
        CFG_DEPTH: dlog_q     <= cfg_wdata_i[DLOG_W-1:0];
        default:   ;
      endcase
    end
  end

  // Classify: channel existence, saturated length, trimmed payload
  always_comb begin
    dst_ok  = (dst_id_i != '0) && reg_mask_q[dst_id_i];
    src_ok  = (src_id_i == '0) || (reg_mask_q[src_id_i] && (src_id_i != dst_id_i));
    len_sat = (length_in_i > LEN_W'(MSG_BYTES)) ? LEN_W'(MSG_BYTES) : length_in_i;

    cmd_o.exists = dst_ok && src_ok;
    if (op_i == OP_SEND) begin
      cmd_o.op = OP_SEND;
    end else if (op_i == OP_RECV) begin
      cmd_o.op = OP_RECV;
    end else begin
      cmd_o.op = OP_READ;
    end
    cmd_o.ch   = {dst_id_i, src_id_i};
    cmd_o.len  = len_sat;
    cmd_o.data = data_in_i & byte_mask(len_sat);
    cmd_o.dlog = (dlog_q == '0) ? DLOG_W'(1) : dlog_q;
  end

  assign full_o     = cmd_full_i;
  assign cmd_push_o = push_i && !cmd_full_i;

endmodule

`default_nettype wire

// ----- src/mcmb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mcmb_back #(
  parameter int RING_SLOTS = mcmb_pkg::RING_SLOTS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mcmb_pkg::cmd_t cmd_i,
  input  wire logic           cmd_empty_i,
  output logic                cmd_pop_o,
  output mcmb_pkg::res_t      res_o,
  output logic                res_push_o,
  input  wire logic           res_full_i
);

  import mcmb_pkg::*;

  localparam int PTR_W   = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int ST_W    = 2 * PTR_W + 2 * CNT_W;
  localparam int PAY_W   = LEN_W + DATA_W;
  localparam int PAY_N   = NUM_CH * RING_SLOTS;
  localparam int PADDR_W = CH_W + PTR_W;

  // Channel record layout: {enq, deq, wp, rp}
  localparam int RP_LO  = 0;
  localparam int WP_LO  = PTR_W;
  localparam int DEQ_LO = 2 * PTR_W;
  localparam int ENQ_LO = 2 * PTR_W + CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_DATA,
    S_RESULT
  } state_e;

  state_e state_q;
  cmd_t   cmd_q;
  res_t   res_q;

  logic [ST_W-1:0]  st_mem [NUM_CH];
  logic [NUM_CH-1:0] st_vld_q;
  logic [ST_W-1:0]  st_rd_q;
  logic             st_rd_vld_q;
  logic             st_re, st_we;
  logic [ST_W-1:0]  st_wdata;

  logic [PAY_W-1:0] pay_mem [PAY_N];
  logic [PAY_W-1:0] pay_rd_q;
  logic             pay_re, pay_we;
  logic [PADDR_W-1:0] pay_raddr, pay_waddr;

  logic [ST_W-1:0]  cur;
  logic [PTR_W-1:0] slot_mask, h, t, h_nxt, t_nxt;
  logic [CNT_W-1:0] enq_cur, deq_cur, enq_nxt, deq_nxt;
  status_e          look_status;
  logic             ring_full, ring_empty;

  assign cmd_pop_o  = (state_q == S_IDLE) && !cmd_empty_i;
  assign st_re      = cmd_pop_o && cmd_i.exists;
  assign res_push_o = (state_q == S_RESULT) && !res_full_i;
  assign res_o      = res_q;

  // Work out the ring step for the latched command
  always_comb begin
    for (int b = 0; b < PTR_W; b++) begin
      slot_mask[b] = (b < int'(cmd_q.dlog));
    end
    cur        = st_rd_vld_q ? st_rd_q : '0;
    h          = cur[RP_LO +: PTR_W] & slot_mask;
    t          = cur[WP_LO +: PTR_W] & slot_mask;
    enq_cur    = cur[ENQ_LO +: CNT_W];
    deq_cur    = cur[DEQ_LO +: CNT_W];
    ring_full  = (t == ((h - 1'b1) & slot_mask));
    ring_empty = (h == t);
    h_nxt      = (h + 1'b1) & slot_mask;
    t_nxt      = (t + 1'b1) & slot_mask;

    enq_nxt     = enq_cur;
    deq_nxt     = deq_cur;
    look_status = STAT_OK;
    st_we       = 1'b0;
    st_wdata    = cur;
    pay_we      = 1'b0;
    pay_re      = 1'b0;
    pay_waddr   = {cmd_q.ch, t};
    pay_raddr   = {cmd_q.ch, h};

    if (state_q == S_LOOK) begin
      unique case (cmd_q.op)
        OP_SEND: begin
          if (ring_full) begin
            look_status = STAT_FULL;
          end else begin
            enq_nxt  = enq_cur + 1'b1;
            st_we    = 1'b1;
            pay_we   = 1'b1;
            st_wdata = {enq_nxt, deq_cur, t_nxt, h};
          end
        end
        OP_RECV: begin
          if (ring_empty) begin
            look_status = STAT_EMPTY;
          end else begin
            deq_nxt  = deq_cur + 1'b1;
            st_we    = 1'b1;
            pay_re   = 1'b1;
            st_wdata = {enq_cur, deq_nxt, t, h_nxt};
          end
        end
        default: ;
      endcase
    end
  end

  // Channel record memory, registered read
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[cmd_q.ch] <= st_wdata;
    end
    if (st_re) begin
      st_rd_q     <= st_mem[cmd_i.ch];
      st_rd_vld_q <= st_vld_q[cmd_i.ch];
    end
  end

  // Mark records written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= '0;
    end else if (st_we) begin
      st_vld_q[cmd_q.ch] <= 1'b1;
    end
  end

  // Message slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[pay_waddr] <= {cmd_q.len, cmd_q.data};
    end
    if (pay_re) begin
      pay_rd_q <= pay_mem[pay_raddr];
    end
  end

  // Sequence one command: look up, update, fetch slot, deliver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= '0;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_pop_o) begin
            cmd_q <= cmd_i;
            if (cmd_i.exists) begin
              state_q <= S_LOOK;
            end else begin
              res_q.status <= STAT_NOCH;
              res_q.data   <= '0;
              res_q.len    <= '0;
              res_q.enq    <= '0;
              res_q.deq    <= '0;
              state_q      <= S_RESULT;
            end
          end
        end
        S_LOOK: begin
          res_q.status <= look_status;
          res_q.data   <= '0;
          res_q.len    <= '0;
          res_q.enq    <= enq_nxt;
          res_q.deq    <= deq_nxt;
          state_q      <= pay_re ? S_DATA : S_RESULT;
        end
        S_DATA: begin
          res_q.len  <= pay_rd_q[DATA_W +: LEN_W];
          res_q.data <= pay_rd_q[DATA_W-1:0];
          state_q    <= S_RESULT;
        end
        S_RESULT: begin
          if (!res_full_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rec_write_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |-> state_q == S_LOOK && cmd_q.exists)
    else $error("channel record written outside lookup");
  a_slot_write_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pay_we |-> cmd_q.op == OP_SEND && !pay_re)
    else $error("slot written for a non-send command");
  a_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> state_q != S_IDLE)
    else $error("command taken but sequencer stayed idle");
  a_fetch_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pay_re |=> state_q == S_DATA)
    else $error("slot fetch not followed by data stage");
`endif

endmodule

`default_nettype wire

// ----- src/multi_channel_message_mailbox.sv -----
// Channel  Direction  Handshake              Beat
// in       input      push / full            op, src_id, dst_id, length_in, data_in
// out      output     empty / pop            status, data_out, length_out, counts
// cfg      input      cfg_we_i (no wait)     cfg_idx_i, cfg_wdata_i
//
// An item whose channel does not exist goes straight to result; a send, a
// failed receive or a counter read passes through lookup, and a successful
// receive adds a data state; the registered record and slot reads set these
// steps. Two-entry queues sit in front of and behind the sequencer, so input
// and output stall independently. Reset clears pointers and counters at once
// through per-channel valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_message_mailbox #(
  parameter int RING_SLOTS = mcmb_pkg::RING_SLOTS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mcmb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mcmb_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [mcmb_pkg::OP_W-1:0]      op_i,
  input  wire logic [mcmb_pkg::ID_W-1:0]      src_id_i,
  input  wire logic [mcmb_pkg::ID_W-1:0]      dst_id_i,
  input  wire logic [mcmb_pkg::LEN_W-1:0]     length_in_i,
  input  wire logic [mcmb_pkg::DATA_W-1:0]    data_in_i,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [mcmb_pkg::STAT_W-1:0]         status_o,
  output logic [mcmb_pkg::DATA_W-1:0]         data_out_o,
  output logic [mcmb_pkg::LEN_W-1:0]          length_out_o,
  output logic [mcmb_pkg::CNT_W-1:0]          enqueue_count_o,
  output logic [mcmb_pkg::CNT_W-1:0]          dequeue_count_o
);

  import mcmb_pkg::*;

  cmd_t cmd_in, cmd_out;
  res_t res_in, res_out;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic res_push, res_full;

  // Classify incoming items
  mcmb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .full_o      (full),
    .op_i        (op_i),
    .src_id_i    (src_id_i),
    .dst_id_i    (dst_id_i),
    .length_in_i (length_in_i),
    .data_in_i   (data_in_i),
    .cmd_o       (cmd_in),
    .cmd_push_o  (cmd_push),
    .cmd_full_i  (cmd_full)
  );

  // Command queue between front and back
  mcmb_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // Carry out ring operations
  mcmb_back #(
    .RING_SLOTS (RING_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // Result queue toward the consumer
  mcmb_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign status_o        = res_out.status;
  assign data_out_o      = res_out.data;
  assign length_out_o    = res_out.len;
  assign enqueue_count_o = res_out.enq;
  assign dequeue_count_o = res_out.deq;

endmodule

`default_nettype wire
